FILE: design/udpdc_pkg.sv
// ---------------------------------------------------------------------------
// udpdc_pkg
// Shared types, constants and the ones' complement fold used by the
// UDP datagram checker.
// ---------------------------------------------------------------------------
package udpdc_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned WordW  = 16;
   localparam int unsigned AddrW  = 32;
   localparam int unsigned StatW  = 3;

   // Offsets of the header bytes within the datagram
   localparam logic [WordW-1:0] OFS_SRC_HI = 16'd0;
   localparam logic [WordW-1:0] OFS_SRC_LO = 16'd1;
   localparam logic [WordW-1:0] OFS_DST_HI = 16'd2;
   localparam logic [WordW-1:0] OFS_DST_LO = 16'd3;
   localparam logic [WordW-1:0] OFS_LEN_HI = 16'd4;
   localparam logic [WordW-1:0] OFS_LEN_LO = 16'd5;
   localparam logic [WordW-1:0] OFS_SUM_HI = 16'd6;
   localparam logic [WordW-1:0] OFS_SUM_LO = 16'd7;

   localparam logic [WordW-1:0] MIN_LEN    = 16'd8;
   localparam logic [WordW-1:0] COUNT_MAX  = 16'hFFFF;
   localparam logic [WordW-1:0] PROTO_WORD = 16'h0011;
   localparam logic [WordW-1:0] SUM_GOOD   = 16'hFFFF;

   typedef enum logic [StatW-1:0] {
      ST_SUM_OK   = 3'd0,
      ST_NO_SUM   = 3'd1,
      ST_SHORT    = 3'd2,
      ST_LEN_BAD  = 3'd3,
      ST_SUM_BAD  = 3'd4
   } status_type;

   // One registered input byte with its pre-folded address sum
   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             last;
      logic [WordW-1:0] addr_sum;
   } item_type;

   typedef struct packed {
      logic             accepted;
      status_type       status;
      logic [WordW-1:0] src_port;
      logic [WordW-1:0] dst_port;
   } result_type;

   // Fold an 18-bit sum of 16-bit words with end-around carry
   function automatic logic [WordW-1:0] oc_fold(input logic [17:0] t);
      logic [16:0] f1;
      logic [16:0] f2;
      f1 = {1'b0, t[15:0]} + {15'd0, t[17:16]};
      f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
      return f2[15:0];
   endfunction

endpackage

FILE: design/udpdc_in_stage.sv
// ---------------------------------------------------------------------------
// udpdc_in_stage
// Input register: hold one byte, its last flag and the folded sum of the
// pseudo-header addresses.
// ---------------------------------------------------------------------------
module udpdc_in_stage (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [udpdc_pkg::ByteW-1:0]  in_data,
   input  logic                         in_last,
   input  logic [udpdc_pkg::AddrW-1:0]  in_src_addr,
   input  logic [udpdc_pkg::AddrW-1:0]  in_dst_addr,
   input  logic                         advance,
   output logic                         in_ready,
   output logic                         item_valid,
   output udpdc_pkg::item_type          item
);

   logic                 valid_ff;
   logic                 valid_in;
   udpdc_pkg::item_type  item_ff;
   udpdc_pkg::item_type  item_in;
   logic [17:0]          addr_total;

   assign in_ready   = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      addr_total = {2'b00, in_src_addr[31:16]} + {2'b00, in_src_addr[15:0]}
                 + {2'b00, in_dst_addr[31:16]} + {2'b00, in_dst_addr[15:0]};
      item_in.data     = in_data;
      item_in.last     = in_last;
      item_in.addr_sum = udpdc_pkg::oc_fold(addr_total);
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

FILE: design/udpdc_check.sv
// ---------------------------------------------------------------------------
// udpdc_check
// Datagram state, checksum accumulation, status decision and the result
// register.
// ---------------------------------------------------------------------------
module udpdc_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  udpdc_pkg::item_type   item,
   input  logic                  out_ready,
   output logic                  res_free,
   output logic                  res_valid,
   output udpdc_pkg::result_type res
);

   logic [15:0] sum_ff, sum_in;
   logic [15:0] count_ff, count_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  held_ff, held_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] csum_ff, csum_in;
   logic [15:0] sport_ff, sport_in;
   logic [15:0] dport_ff, dport_in;

   logic                  rv_ff, rv_in;
   udpdc_pkg::result_type res_ff, res_in;

   logic        start;
   logic        full;
   logic [15:0] base;
   logic [15:0] word;
   logic [15:0] last_word;
   logic [17:0] total;
   logic        sum_good;
   udpdc_pkg::status_type st;

   assign res_free  = !rv_ff || out_ready;
   assign res_valid = rv_ff;
   assign res       = res_ff;

   always_comb begin
      start = (count_ff == 16'd0) && !ovf_ff;
      full  = (count_ff == udpdc_pkg::COUNT_MAX);
      base  = start ? item.addr_sum : sum_ff;
      word  = {held_ff, item.data};

      sum_in   = base;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      held_in  = held_ff;
      len_in   = len_ff;
      csum_in  = csum_ff;
      sport_in = sport_ff;
      dport_in = dport_ff;

      if (full) begin
         ovf_in = 1'b1;
      end else begin
         case (count_ff)
            udpdc_pkg::OFS_SRC_HI: sport_in = {item.data, 8'h00};
            udpdc_pkg::OFS_SRC_LO: sport_in = {sport_ff[15:8], item.data};
            udpdc_pkg::OFS_DST_HI: dport_in = {item.data, 8'h00};
            udpdc_pkg::OFS_DST_LO: dport_in = {dport_ff[15:8], item.data};
            udpdc_pkg::OFS_LEN_HI: len_in   = {item.data, 8'h00};
            udpdc_pkg::OFS_LEN_LO: len_in   = {len_ff[15:8], item.data};
            udpdc_pkg::OFS_SUM_HI: csum_in  = {item.data, 8'h00};
            udpdc_pkg::OFS_SUM_LO: csum_in  = {csum_ff[15:8], item.data};
            default: ;
         endcase
         if (!count_ff[0]) begin
            held_in = item.data;
         end else begin
            sum_in = udpdc_pkg::oc_fold({2'b00, base} + {2'b00, word});
         end
         count_in = count_ff + 16'd1;
      end

      // Closing word: completed pair on an odd offset, zero-padded byte on
      // an even one. Only meaningful when no overflow is flagged.
      last_word = count_ff[0] ? word : {item.data, 8'h00};
      total     = {2'b00, base} + {2'b00, last_word}
                + {2'b00, udpdc_pkg::PROTO_WORD} + {2'b00, count_in};
      sum_good  = (udpdc_pkg::oc_fold(total) == udpdc_pkg::SUM_GOOD);

      if (count_in < udpdc_pkg::MIN_LEN) begin
         st = udpdc_pkg::ST_SHORT;
      end else if (ovf_in || (len_in != count_in)) begin
         st = udpdc_pkg::ST_LEN_BAD;
      end else if (csum_in == 16'd0) begin
         st = udpdc_pkg::ST_NO_SUM;
      end else if (sum_good) begin
         st = udpdc_pkg::ST_SUM_OK;
      end else begin
         st = udpdc_pkg::ST_SUM_BAD;
      end

      res_in.accepted = (st == udpdc_pkg::ST_SUM_OK) || (st == udpdc_pkg::ST_NO_SUM);
      res_in.status   = st;
      res_in.src_port = (st == udpdc_pkg::ST_SHORT) ? 16'd0 : sport_in;
      res_in.dst_port = (st == udpdc_pkg::ST_SHORT) ? 16'd0 : dport_in;

      rv_in = rv_ff && !out_ready;
      if (fire && item.last) begin
         rv_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff    <= 1'b0;
         sum_ff   <= 16'd0;
         count_ff <= 16'd0;
         ovf_ff   <= 1'b0;
         held_ff  <= 8'd0;
         len_ff   <= 16'd0;
         csum_ff  <= 16'd0;
         sport_ff <= 16'd0;
         dport_ff <= 16'd0;
      end else begin
         rv_ff <= rv_in;
         if (fire) begin
            if (item.last) begin
               sum_ff   <= 16'd0;
               count_ff <= 16'd0;
               ovf_ff   <= 1'b0;
               held_ff  <= 8'd0;
               len_ff   <= 16'd0;
               csum_ff  <= 16'd0;
               sport_ff <= 16'd0;
               dport_ff <= 16'd0;
            end else begin
               sum_ff   <= sum_in;
               count_ff <= count_in;
               ovf_ff   <= ovf_in;
               held_ff  <= held_in;
               len_ff   <= len_in;
               csum_ff  <= csum_in;
               sport_ff <= sport_in;
               dport_ff <= dport_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && item.last) begin
         res_ff <= res_in;
      end
   end

endmodule

FILE: design/udp_datagram_checker_core.sv
// ---------------------------------------------------------------------------
// udp_datagram_checker_core
// A byte marked last waits in the input register until the result register is
// free, then loads it. Throughput: one byte per cycle while no closing byte
// waits, set by the single ones' complement adder pass between the two.
// Reset: synchronous, active high; clears both stage valids and all datagram
// state, so the next byte starts a new datagram.
// ---------------------------------------------------------------------------
module udp_datagram_checker_core (
   input  logic        clock,
   input  logic        reset,
   // Byte stream in
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] data_byte, [39:8] source_address, [71:40] dest_address
   input  logic [71:0] req_tdata,
   input  logic        req_tlast,
   // Verdict out, one transaction per datagram
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] accepted, [3:1] status, [19:4] source_port, [35:20] dest_port,
   // [39:36] zero
   output logic [39:0] rsp_tdata
);

   udpdc_pkg::item_type   item;
   udpdc_pkg::result_type res;
   logic                  item_valid;
   logic                  res_free;
   logic                  advance;

   // Advance the input register whenever it holds a byte, unless that byte
   // closes a datagram and the result register is still occupied. Middle
   // bytes never wait on the result side.
   assign advance = item_valid && (!item.last || res_free);

   // Register the incoming transaction and pre-fold the pseudo-header
   // addresses so the accumulation step sees a single 16-bit word.
   udpdc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_data     (req_tdata[7:0]),
      .in_last     (req_tlast),
      .in_src_addr (req_tdata[39:8]),
      .in_dst_addr (req_tdata[71:40]),
      .advance     (advance),
      .in_ready    (req_tready),
      .item_valid  (item_valid),
      .item        (item)
   );

   // Accumulate the checksum, capture header fields, and on the closing
   // byte decide the status and load the result register.
   udpdc_check u_check (
      .clock     (clock),
      .reset     (reset),
      .fire      (advance),
      .item      (item),
      .out_ready (rsp_tready),
      .res_free  (res_free),
      .res_valid (rsp_tvalid),
      .res       (res)
   );

   // Pack the verdict, lowest field first, padded to whole bytes
   assign rsp_tdata = {4'd0, res.dst_port, res.src_port, res.status, res.accepted};

endmodule

FILE: verif/tb_udp_datagram_checker_core.sv
// ---------------------------------------------------------------------------
// tb_udp_datagram_checker_core
// Self-checking bench for the UDP datagram checker. Datagrams are streamed in
// one byte per transaction: a short directed set, then mostly well-formed
// datagrams with random content mixed with bad checksums, bad lengths, short
// frames and noise. A local model of the checksum and header logic predicts
// each verdict, and every verdict that leaves the block is compared field by
// field against it. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module tb_udp_datagram_checker_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RUN_LIMIT     = 50_000;
   localparam int unsigned RANDOM_BYTES  = 840;
   localparam int unsigned DRAIN_CYCLES  = 10;
   localparam int unsigned QUIET_FROM    = 450;
   localparam int unsigned QUIET_TO      = 650;

   typedef enum {
      DG_GOOD,
      DG_NO_SUM,
      DG_BAD_SUM,
      DG_BAD_LEN,
      DG_NOISE
   } dgram_kind_type;

   // One byte of the stream with the addresses presented beside it
   typedef struct {
      logic [udpdc_pkg::ByteW-1:0] data;
      logic                        last;
      logic [udpdc_pkg::AddrW-1:0] src;
      logic [udpdc_pkg::AddrW-1:0] dst;
   } byte_item_type;

   // One verdict as the checker should report it
   typedef struct {
      logic                        accepted;
      udpdc_pkg::status_type       status;
      logic [udpdc_pkg::WordW-1:0] src_port;
      logic [udpdc_pkg::WordW-1:0] dst_port;
   } verdict_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata  = '0;    // [7:0] byte, [39:8] source addr, [71:40] dest addr
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // [0] accepted, [3:1] status, [19:4] src port,
                                    // [35:20] dest port, [39:36] zero

   byte_item_type pending_bytes[$]; // stimulus not yet offered
   byte_item_type drv_item;         // byte currently on the request bus
   verdict_type   verdicts_due[$];  // predicted verdicts, oldest first

   int unsigned cycle_no   = 0;
   int unsigned mismatches = 0;
   logic        quiet;

   // Checker model state, cleared after every last byte
   logic [udpdc_pkg::WordW-1:0] acc_sum       = '0;
   logic [udpdc_pkg::WordW-1:0] seen_count    = '0;
   logic                        seen_overflow = 1'b0;
   logic [udpdc_pkg::ByteW-1:0] pend_hi       = '0;
   logic [udpdc_pkg::WordW-1:0] len_word      = '0;
   logic [udpdc_pkg::WordW-1:0] csum_word     = '0;
   logic [udpdc_pkg::WordW-1:0] sport_word    = '0;
   logic [udpdc_pkg::WordW-1:0] dport_word    = '0;

   udp_datagram_checker_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
   end

   // Window in which neither side idles, so back-to-back traffic is seen too
   assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

   // Ones' complement addition with end-around carry
   function automatic logic [udpdc_pkg::WordW-1:0] ones_add(
         input logic [udpdc_pkg::WordW-1:0] a,
         input logic [udpdc_pkg::WordW-1:0] b);
      logic [udpdc_pkg::WordW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[udpdc_pkg::WordW-1:0] + {{(udpdc_pkg::WordW-1){1'b0}}, s[udpdc_pkg::WordW]};
   endfunction

   // Advance the checker model by one accepted byte; on a last byte queue the
   // verdict and clear the model for the next datagram.
   task automatic track_byte(input byte_item_type it);
      verdict_type                 v;
      logic [udpdc_pkg::WordW-1:0] total;
      logic [udpdc_pkg::WordW-1:0] pos;
      // The first byte of a datagram restarts the sum from the addresses
      if (seen_count == '0 && !seen_overflow) begin
         acc_sum = ones_add(16'd0, it.src[31:16]);
         acc_sum = ones_add(acc_sum, it.src[15:0]);
         acc_sum = ones_add(acc_sum, it.dst[31:16]);
         acc_sum = ones_add(acc_sum, it.dst[15:0]);
      end
      if (seen_count == udpdc_pkg::COUNT_MAX) begin
         // Neither counted nor summed; the datagram is doomed to a length error
         seen_overflow = 1'b1;
      end else begin
         pos = seen_count;
         case (pos)
            udpdc_pkg::OFS_SRC_HI: sport_word = {it.data, 8'h00};
            udpdc_pkg::OFS_SRC_LO: sport_word = sport_word | {8'h00, it.data};
            udpdc_pkg::OFS_DST_HI: dport_word = {it.data, 8'h00};
            udpdc_pkg::OFS_DST_LO: dport_word = dport_word | {8'h00, it.data};
            udpdc_pkg::OFS_LEN_HI: len_word   = {it.data, 8'h00};
            udpdc_pkg::OFS_LEN_LO: len_word   = len_word | {8'h00, it.data};
            udpdc_pkg::OFS_SUM_HI: csum_word  = {it.data, 8'h00};
            udpdc_pkg::OFS_SUM_LO: csum_word  = csum_word | {8'h00, it.data};
            default: ;
         endcase
         // Even offsets open a big-endian word, odd offsets complete it
         if (!pos[0]) begin
            pend_hi = it.data;
         end else begin
            acc_sum = ones_add(acc_sum, {pend_hi, it.data});
         end
         seen_count = pos + 16'd1;
      end
      if (it.last) begin
         // Pad an odd tail with zero, then fold in protocol and UDP length
         total = acc_sum;
         if (!seen_overflow && seen_count[0]) begin
            total = ones_add(total, {pend_hi, 8'h00});
         end
         total = ones_add(total, udpdc_pkg::PROTO_WORD);
         total = ones_add(total, seen_count);
         if (seen_count < udpdc_pkg::MIN_LEN) begin
            v.status = udpdc_pkg::ST_SHORT;
         end else if (seen_overflow || len_word != seen_count) begin
            v.status = udpdc_pkg::ST_LEN_BAD;
         end else if (csum_word == '0) begin
            v.status = udpdc_pkg::ST_NO_SUM;
         end else if (total == udpdc_pkg::SUM_GOOD) begin
            v.status = udpdc_pkg::ST_SUM_OK;
         end else begin
            v.status = udpdc_pkg::ST_SUM_BAD;
         end
         v.accepted = (v.status == udpdc_pkg::ST_SUM_OK) ||
                      (v.status == udpdc_pkg::ST_NO_SUM);
         v.src_port = (v.status == udpdc_pkg::ST_SHORT) ? '0 : sport_word;
         v.dst_port = (v.status == udpdc_pkg::ST_SHORT) ? '0 : dport_word;
         verdicts_due.push_back(v);
         acc_sum       = '0;
         seen_count    = '0;
         seen_overflow = 1'b0;
         pend_hi       = '0;
         len_word      = '0;
         csum_word     = '0;
         sport_word    = '0;
         dport_word    = '0;
      end
   endtask

   // Build one datagram of n bytes and queue it byte by byte. Well-formed
   // kinds need n of at least 8; noise is random bytes of any length.
   task automatic queue_datagram(input dgram_kind_type              kind,
                                 input int unsigned                 n,
                                 input logic [udpdc_pkg::AddrW-1:0] sa,
                                 input logic [udpdc_pkg::AddrW-1:0] da,
                                 input logic [udpdc_pkg::WordW-1:0] sp,
                                 input logic [udpdc_pkg::WordW-1:0] dp);
      logic [udpdc_pkg::ByteW-1:0] octets[$];
      logic [31:0]                 acc;
      logic [udpdc_pkg::WordW-1:0] lenw;
      logic [udpdc_pkg::WordW-1:0] cs;
      logic [udpdc_pkg::WordW-1:0] flip;
      byte_item_type               it;
      for (int unsigned i = 0; i < n; i++) begin
         octets.push_back(8'($urandom_range(255)));
      end
      if (kind != DG_NOISE) begin
         lenw = 16'(n);
         if (kind == DG_BAD_LEN) begin
            flip = 16'($urandom_range(65535, 1));
            lenw = lenw ^ flip;
         end
         octets[0] = sp[15:8];
         octets[1] = sp[7:0];
         octets[2] = dp[15:8];
         octets[3] = dp[7:0];
         octets[4] = lenw[15:8];
         octets[5] = lenw[7:0];
         octets[6] = 8'h00;
         octets[7] = 8'h00;
         // Plain 32-bit sum over pseudo-header and data, folded at the end
         acc = sa[31:16] + sa[15:0] + da[31:16] + da[15:0] + udpdc_pkg::PROTO_WORD
             + (n & 32'hFFFF);
         for (int unsigned i = 0; i < n; i += 2) begin
            acc = acc + {16'd0, octets[i], (i + 1 < n) ? octets[i + 1] : 8'h00};
         end
         while (acc[31:16] != 16'd0) begin
            acc = {16'd0, acc[15:0]} + {16'd0, acc[31:16]};
         end
         cs = ~acc[15:0];
         if (cs == '0) begin
            cs = 16'hFFFF;
         end
         if (kind == DG_NO_SUM) begin
            cs = '0;
         end else if (kind == DG_BAD_SUM) begin
            cs = cs ^ (16'd1 << $urandom_range(15));
            if (cs == '0) begin
               cs = 16'hFFFE;
            end
         end
         octets[6] = cs[15:8];
         octets[7] = cs[7:0];
      end
      for (int unsigned i = 0; i < n; i++) begin
         it.data = octets[i];
         it.last = (i == n - 1);
         // Addresses matter on the first byte only; scramble them elsewhere
         it.src  = (i == 0) ? sa : $urandom;
         it.dst  = (i == 0) ? da : $urandom;
         pending_bytes.push_back(it);
      end
   endtask

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: verdict %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, want, got);
      end
   endtask

   // Stimulus: directed corners, then random traffic
   initial begin
      int unsigned                 n;
      int unsigned                 r;
      int unsigned                 target;
      dgram_kind_type              kind;
      logic [udpdc_pkg::AddrW-1:0] sa;
      logic [udpdc_pkg::AddrW-1:0] da;
      logic [udpdc_pkg::WordW-1:0] sp;
      logic [udpdc_pkg::WordW-1:0] dp;

      // Single-byte and seven-byte frames are too short
      queue_datagram(DG_NOISE, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
      queue_datagram(DG_NOISE, 7, 32'h0, 32'h0, '0, '0);
      // Header-only datagrams at the address and port extremes
      queue_datagram(DG_GOOD, 8, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
      queue_datagram(DG_GOOD, 8, 32'h0, 32'h0, 16'h0, 16'h0);
      // Odd length forces the zero pad byte
      queue_datagram(DG_GOOD, 9, 32'hC0A8_0001, 32'h0A00_0002, 16'd53, 16'd4000);
      queue_datagram(DG_NO_SUM, 10, $urandom, $urandom, 16'($urandom), 16'($urandom));
      queue_datagram(DG_BAD_SUM, 11, $urandom, $urandom, 16'($urandom), 16'($urandom));
      queue_datagram(DG_BAD_LEN, 8, $urandom, $urandom, 16'($urandom), 16'($urandom));

      // Mostly well-formed datagrams with random content
      target = pending_bytes.size() + RANDOM_BYTES;
      while (pending_bytes.size() < target) begin
         r = $urandom_range(99);
         if (r < 8) begin
            n = $urandom_range(7, 1);
         end else if (r < 88) begin
            n = $urandom_range(48, 8);
         end else begin
            n = $urandom_range(400, 49);
         end
         // Trim the final datagram so the byte budget is kept
         if (n > target - pending_bytes.size()) begin
            n = target - pending_bytes.size();
         end
         r = $urandom_range(99);
         if (n < 8 || r >= 92) begin
            kind = DG_NOISE;
         end else if (r < 60) begin
            kind = DG_GOOD;
         end else if (r < 71) begin
            kind = DG_NO_SUM;
         end else if (r < 82) begin
            kind = DG_BAD_SUM;
         end else begin
            kind = DG_BAD_LEN;
         end
         sa = ($urandom_range(15) == 0) ? 32'hFFFF_FFFF : $urandom;
         da = ($urandom_range(15) == 0) ? 32'h0 : $urandom;
         sp = ($urandom_range(15) == 0) ? 16'hFFFF : 16'($urandom);
         dp = ($urandom_range(15) == 0) ? 16'h0 : 16'($urandom);
         queue_datagram(kind, n, sa, da, sp, dp);
      end

      // Drain: every byte taken, every verdict back, then let the pipe settle
      while (pending_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Request driver: predict on each accepted transaction, then offer the
   // next byte unless this cycle idles. Hold the bus while it is stalled.
   always @(posedge clock) begin : p_driver
      logic idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            track_byte(drv_item);
         end
         if (!req_tvalid || req_tready) begin
            idle = !quiet && ($urandom_range(99) < 11);
            if (pending_bytes.size() != 0 && !idle) begin
               drv_item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drv_item.dst, drv_item.src, drv_item.data};
               req_tlast  <= drv_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Verdict monitor: stall at random and check each accepted transaction
   // against the oldest prediction.
   always @(posedge clock) begin : p_monitor
      verdict_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 11);
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected verdict, expected none, actual 0x%0h",
                        $time, rsp_tdata);
            end else begin
               want = verdicts_due.pop_front();
               report_field("accepted", want.accepted, rsp_tdata[0]);
               report_field("status", want.status, rsp_tdata[3:1]);
               report_field("source_port", want.src_port, rsp_tdata[19:4]);
               report_field("dest_port", want.dst_port, rsp_tdata[35:20]);
               report_field("padding", 0, rsp_tdata[39:36]);
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
      if (cycle_no >= RUN_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

endmodule
